@@ rtl/sqtr_pkg.sv @@
// ----------------------------------------------------------------------------
// sqtr_pkg
// Shared types and codes for the sleep queue with tick release.
// ----------------------------------------------------------------------------
package sqtr_pkg;

    localparam int ID_W    = 16;
    localparam int COUNT_W = 16;
    localparam int KIND_W  = 2;

    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED = 2'd2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_TICK
    } sqtr_state_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic               shift;
        logic               load;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } sqtr_cell_ctl_t;

endpackage

@@ rtl/sqtr_cell.sv @@
// ----------------------------------------------------------------------------
// sqtr_cell
// One slot of the sleep list: holds an id and a remaining tick count.
// Takes its right neighbor's entry on a shift, or the broadcast entry when
// the load index names this slot.
// ----------------------------------------------------------------------------
module sqtr_cell
    import sqtr_pkg::*;
#(
    parameter int IW  = 5,
    parameter int IDX = 0
)
(
    input  logic               clk,
    input  sqtr_cell_ctl_t     ctl,
    input  logic [IW-1:0]      load_idx,
    input  logic [ID_W-1:0]    nbr_id,
    input  logic [COUNT_W-1:0] nbr_count,
    output logic [ID_W-1:0]    id,
    output logic [COUNT_W-1:0] count
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        id_next    = id_reg;
        count_next = count_reg;
        if (ctl.load && (load_idx == MY_IDX))
        begin
            id_next    = ctl.id;
            count_next = ctl.count;
        end
        else if (ctl.shift)
        begin
            id_next    = nbr_id;
            count_next = nbr_count;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        count_reg <= count_next;
    end

    assign id    = id_reg;
    assign count = count_reg;

endmodule

@@ rtl/sleep_queue_tick_release.sv @@
// ----------------------------------------------------------------------------
// sleep_queue_tick_release
// Ordered list of sleeping processes kept in a chain of SLOTS cells.
// ----------------------------------------------------------------------------
// An insert is accepted, then appended at the tail and answered, or rejected
// if all slots are full. A tick pass shifts the chain toward the head once per
// entry: the head entry is examined, survivors are decremented and rewritten
// at the tail, released ids go out one per cycle while the result port does
// not stall, the final one marked last. A stalled result port holds the tick
// pass at the next due entry and holds an insert until its answer can be
// registered. One item is worked on at a time; cmd_stall is high until done.
// ----------------------------------------------------------------------------
module sleep_queue_tick_release
    import sqtr_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  logic               command,
    input  logic [ID_W-1:0]    proc_id,
    input  logic [COUNT_W-1:0] delay_ticks,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [ID_W-1:0]    released_id,
    output logic               last
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OW = $clog2(SLOTS + 1);
    localparam logic [OW-1:0] FULL = OW'(SLOTS);

    sqtr_state_t        state_reg, state_next;
    logic [OW-1:0]      occ_reg, occ_next;
    logic [OW-1:0]      todo_reg, todo_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic [ID_W-1:0]    ins_id_reg, ins_id_next;
    logic [COUNT_W-1:0] ins_delay_reg, ins_delay_next;
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic               out_last_reg, out_last_next;

    sqtr_cell_ctl_t     ctl;
    logic [IW-1:0]      load_idx;
    logic [ID_W-1:0]    cell_id    [SLOTS];
    logic [COUNT_W-1:0] cell_count [SLOTS];
    logic               out_free;
    logic               head_due;

    assign out_free = !out_valid_reg || !rsp_stall;
    assign head_due = (cell_count[0] <= COUNT_W'(1));

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            logic [ID_W-1:0]    nbr_id;
            logic [COUNT_W-1:0] nbr_count;
            if (g == SLOTS - 1)
            begin : g_end
                assign nbr_id    = '0;
                assign nbr_count = '0;
            end
            else
            begin : g_mid
                assign nbr_id    = cell_id[g+1];
                assign nbr_count = cell_count[g+1];
            end
            sqtr_cell #(
                .IW  (IW),
                .IDX (g)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .load_idx  (load_idx),
                .nbr_id    (nbr_id),
                .nbr_count (nbr_count),
                .id        (cell_id[g]),
                .count     (cell_count[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        todo_next       = todo_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        ins_id_next     = ins_id_reg;
        ins_delay_next  = ins_delay_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        ctl             = '0;
        load_idx        = '0;
        cmd_stall       = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (command == CMD_INSERT)
                    begin
                        ins_id_next    = proc_id;
                        ins_delay_next = delay_ticks;
                        state_next     = ST_INSERT;
                    end
                    else
                    begin
                        todo_next       = occ_reg;
                        pend_valid_next = 1'b0;
                        state_next      = ST_TICK;
                    end
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = ins_id_reg;
                    out_last_next  = 1'b1;
                    if (occ_reg == FULL)
                    begin
                        out_kind_next = KIND_REJECTED;
                    end
                    else
                    begin
                        out_kind_next = KIND_ACCEPTED;
                        ctl.load      = 1'b1;
                        ctl.id        = ins_id_reg;
                        ctl.count     = (ins_delay_reg == '0) ? COUNT_W'(1) : ins_delay_reg;
                        load_idx      = occ_reg[IW-1:0];
                        occ_next      = occ_reg + OW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (todo_reg == '0)
                begin
                    if (!pend_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = KIND_RELEASED;
                        out_id_next     = pend_id_reg;
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
                else if (head_due)
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_RELEASED;
                            out_id_next    = pend_id_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = cell_id[0];
                        ctl.shift       = 1'b1;
                        occ_next        = occ_reg - OW'(1);
                        todo_next       = todo_reg - OW'(1);
                    end
                end
                else
                begin
                    ctl.shift = 1'b1;
                    ctl.load  = 1'b1;
                    ctl.id    = cell_id[0];
                    ctl.count = cell_count[0] - COUNT_W'(1);
                    load_idx  = IW'(occ_reg - OW'(1));
                    todo_next = todo_reg - OW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            todo_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            todo_reg       <= todo_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        ins_id_reg    <= ins_id_next;
        ins_delay_reg <= ins_delay_next;
        out_kind_reg  <= out_kind_next;
        out_id_reg    <= out_id_next;
        out_last_reg  <= out_last_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign released_id = out_id_reg;
    assign last        = out_last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL)
        else $error("occupancy above slot count");

    a_todo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK) |-> (todo_reg <= occ_reg))
        else $error("tick pass count exceeds occupancy");

    a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_TICK))
        else $error("pending release outside tick pass");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=>
            (rsp_valid && $stable(kind) && $stable(released_id) && $stable(last)))
        else $error("stalled response transfer changed");

endmodule
